/* hdl/rsi_pkg.sv */
// Shared widths, register codes and carried-payload types for the ray / sphere
// intersection pipeline. No dependencies.
package rsi_pkg;

    localparam int FRAC_BITS_DEF = 16;

    localparam int COORD_W = 32;             // Q16.16 coordinates and t
    localparam int RAD_W   = 31;             // sphere radius
    localparam int NORM_W  = 19;             // normal component
    localparam int NORM_LIM = 131072;        // normal magnitude bound

    localparam int IN_W   = 8 * COORD_W;     // s_tdata
    localparam int OUT_W  = 192;             // m_tdata, padded to bytes
    localparam int USER_W = 2;               // m_tuser

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Z = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS   = 2'd3;

    localparam int E_W    = COORD_W + 1;     // origin - center
    localparam int A_W    = 64;              // d.d
    localparam int H_W    = 67;              // d.e, signed
    localparam int C_W    = 68;              // e.e - r^2, signed
    localparam int LIMB_W = 32;
    localparam int N_LIMB = 3;
    localparam int LIMBS_W = LIMB_W * N_LIMB;
    localparam int DISC_W = 132;             // non-negative discriminant
    localparam int DSUM_W = DISC_W + 2;      // signed discriminant sum
    localparam int SQ_N   = DISC_W / 2;      // root bits
    localparam int REM_W  = SQ_N + 2;        // root remainder
    localparam int NR_W   = H_W + 2;         // -h +/- root
    localparam int PW     = COORD_W * 2 + 1; // unsaturated hit point
    localparam int DIFF_W = PW + 1;          // point - center

    typedef struct {
        logic signed [COORD_W-1:0] o [3];
        logic signed [COORD_W-1:0] d [3];
        logic signed [COORD_W-1:0] tlo;
        logic signed [COORD_W-1:0] thi;
    } ray_t;

    typedef struct {
        ray_t                  ray;
        logic signed [H_W-1:0] h;
        logic [A_W-1:0]        a;
        logic                  miss;
    } sqc_t;

    typedef struct {
        ray_t           ray;
        logic [A_W-1:0] a;
        logic           miss;
        logic           neg [2];
    } dvc_t;

    typedef struct {
        logic                      hit;
        logic                      back;
        logic signed [COORD_W-1:0] tt;
        logic signed [COORD_W-1:0] psat [3];
        logic                      neg [3];
    } ndc_t;

endpackage

/* hdl/ray_sphere_intersect.sv */
// Ray / sphere intersection top level: fully pipelined quadratic solve, root,
// divisions, hit point and normal. Depends on rsi_pkg.
//
//  channel   ports                               width      direction
//  ray in    s_tvalid s_tready s_tdata           256        in
//  result    m_tvalid m_tready m_tdata m_tuser   192 + 2    out
//  config    cfg_we cfg_addr cfg_wdata           2 + 32     in
//
// One ray enters per cycle while s_tready is high. The pipeline has 2*FRAC_BITS + 215
// register stages (247 at Q16.16), set by the 66-step root, the (68 + FRAC_BITS)-step t
// dividers and the (66 + FRAC_BITS)-step normal dividers, one bit per stage.
// Reset is synchronous, active low, clears valid bits; sphere resets to r = 1.0.
// A stalled output parks one item in a skid register; the pipeline then holds.
module ray_sphere_intersect
    import rsi_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_addr,
    input  logic [COORD_W-1:0]   cfg_wdata,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, t_lower, t_upper
    input  logic [IN_W-1:0]      s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // distance, point_x, point_y, point_z, normal_x, normal_y, normal_z, zero pad
    output logic [OUT_W-1:0]     m_tdata,
    // is_hit, back_face
    output logic [USER_W-1:0]    m_tuser
);

    localparam int NUM_W = NR_W - 1 + FRAC_BITS;   // t numerator magnitude
    localparam int TW    = NUM_W + 1;
    localparam int NN_W  = DIFF_W + FRAC_BITS;     // normal numerator magnitude
    localparam logic [RAD_W-1:0] RAD_ONE = RAD_W'(1) << FRAC_BITS;
    localparam logic signed [PW-1:0] P_MAX = PW'(64'sd2147483647);
    localparam logic signed [PW-1:0] P_MIN = PW'(-64'sd2147483648);

    // ---------------- configuration ----------------
    logic signed [COORD_W-1:0] cen_reg [3];
    logic [RAD_W-1:0]          rad_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cen_reg[0] <= '0;
            cen_reg[1] <= '0;
            cen_reg[2] <= '0;
            rad_reg    <= RAD_ONE;
        end else if (cfg_we) begin
            case (cfg_addr)
                CFG_CENTER_X: cen_reg[0] <= cfg_wdata;
                CFG_CENTER_Y: cen_reg[1] <= cfg_wdata;
                CFG_CENTER_Z: cen_reg[2] <= cfg_wdata;
                CFG_RADIUS:   rad_reg    <= cfg_wdata[RAD_W-1:0];
                default: ;
            endcase
        end
    end

    logic en;
    logic skid_v_reg;
    assign en       = !skid_v_reg;
    assign s_tready = en;

    ray_t ray_in;
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            ray_in.o[i] = s_tdata[COORD_W*i +: COORD_W];
            ray_in.d[i] = s_tdata[COORD_W*(3+i) +: COORD_W];
        end
        ray_in.tlo = s_tdata[COORD_W*6 +: COORD_W];
        ray_in.thi = s_tdata[COORD_W*7 +: COORD_W];
    end

    // ---------------- stage 1: e = origin - center ----------------
    logic                  v1_reg;
    ray_t                  r1_reg;
    logic signed [E_W-1:0] e1_reg [3];

    always_ff @(posedge aclk) begin
        if (!aresetn) v1_reg <= 1'b0;
        else if (en)  v1_reg <= s_tvalid;
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            r1_reg <= ray_in;
            for (int i = 0; i < 3; i++)
                e1_reg[i] <= E_W'(ray_in.o[i]) - E_W'(cen_reg[i]);
        end
    end

    // ---------------- stage 2: component products ----------------
    logic                    v2_reg;
    ray_t                    r2_reg;
    logic [A_W-1:0]          dd2_reg [3];
    logic signed [E_W+31:0]  de2_reg [3];
    logic [2*E_W-1:0]        ee2_reg [3];
    logic [2*RAD_W-1:0]      rr2_reg;
    logic signed [A_W-1:0]   dd_next [3];
    logic signed [E_W+31:0]  de_next [3];
    logic signed [2*E_W-1:0] ee_next [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            dd_next[i] = r1_reg.d[i] * r1_reg.d[i];
            de_next[i] = r1_reg.d[i] * e1_reg[i];
            ee_next[i] = e1_reg[i] * e1_reg[i];
        end
    end
    always_ff @(posedge aclk) begin
        if (!aresetn) v2_reg <= 1'b0;
        else if (en)  v2_reg <= v1_reg;
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            r2_reg  <= r1_reg;
            for (int i = 0; i < 3; i++) begin
                dd2_reg[i] <= dd_next[i];
                de2_reg[i] <= de_next[i];
                ee2_reg[i] <= ee_next[i];
            end
            rr2_reg <= rad_reg * rad_reg;
        end
    end

    // ---------------- stage 3: A, h, C ----------------
    logic                  v3_reg;
    ray_t                  r3_reg;
    logic [A_W-1:0]        a3_reg;
    logic signed [H_W-1:0] h3_reg;
    logic signed [C_W-1:0] c3_reg;
    logic                  z3_reg;
    logic [A_W-1:0]        a_next;
    logic signed [H_W-1:0] h_next;
    logic signed [C_W-1:0] c_next;

    always_comb begin
        a_next = dd2_reg[0] + dd2_reg[1] + dd2_reg[2];
        h_next = H_W'(de2_reg[0]) + H_W'(de2_reg[1]) + H_W'(de2_reg[2]);
        c_next = C_W'(ee2_reg[0]) + C_W'(ee2_reg[1]) + C_W'(ee2_reg[2]) - C_W'(rr2_reg);
    end
    always_ff @(posedge aclk) begin
        if (!aresetn) v3_reg <= 1'b0;
        else if (en)  v3_reg <= v2_reg;
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            r3_reg <= r2_reg;
            a3_reg <= a_next;
            h3_reg <= h_next;
            c3_reg <= c_next;
            z3_reg <= (a_next == '0) || (rad_reg == '0);
        end
    end

    // ---------------- stage 4: magnitudes for the wide products ----------------
    logic                  v4_reg;
    ray_t                  r4_reg;
    logic [A_W-1:0]        a4_reg;
    logic signed [H_W-1:0] h4_reg;
    logic [LIMBS_W-1:0]    hab4_reg;
    logic [LIMBS_W-1:0]    cab4_reg;
    logic                  cneg4_reg;
    logic                  z4_reg;
    logic signed [H_W-1:0] habs_next;
    logic signed [C_W-1:0] cabs_next;

    always_comb begin
        habs_next = h3_reg[H_W-1] ? -h3_reg : h3_reg;
        cabs_next = c3_reg[C_W-1] ? -c3_reg : c3_reg;
    end
    always_ff @(posedge aclk) begin
        if (!aresetn) v4_reg <= 1'b0;
        else if (en)  v4_reg <= v3_reg;
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            r4_reg    <= r3_reg;
            a4_reg    <= a3_reg;
            h4_reg    <= h3_reg;
            hab4_reg  <= LIMBS_W'(unsigned'(habs_next));
            cab4_reg  <= LIMBS_W'(unsigned'(cabs_next));
            cneg4_reg <= c3_reg[C_W-1];
            z4_reg    <= z3_reg;
        end
    end

    // ---------------- stage 5: 32x32 partial products ----------------
    logic                    v5_reg;
    ray_t                    r5_reg;
    logic [A_W-1:0]          a5_reg;
    logic signed [H_W-1:0]   h5_reg;
    logic [2*LIMB_W-1:0]     hpp5_reg [N_LIMB][N_LIMB];
    logic [2*LIMB_W-1:0]     app5_reg [2][N_LIMB];
    logic                    cneg5_reg;
    logic                    z5_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) v5_reg <= 1'b0;
        else if (en)  v5_reg <= v4_reg;
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            r5_reg    <= r4_reg;
            a5_reg    <= a4_reg;
            h5_reg    <= h4_reg;
            cneg5_reg <= cneg4_reg;
            z5_reg    <= z4_reg;
            for (int i = 0; i < N_LIMB; i++) begin
                for (int j = 0; j < N_LIMB; j++)
                    hpp5_reg[i][j] <= hab4_reg[LIMB_W*i +: LIMB_W]
                                    * hab4_reg[LIMB_W*j +: LIMB_W];
            end
            for (int i = 0; i < 2; i++) begin
                for (int j = 0; j < N_LIMB; j++)
                    app5_reg[i][j] <= a4_reg[LIMB_W*i +: LIMB_W]
                                    * cab4_reg[LIMB_W*j +: LIMB_W];
            end
        end
    end

    // ---------------- stage 6: h^2 and A*|C| ----------------
    logic                  v6_reg;
    ray_t                  r6_reg;
    logic [A_W-1:0]        a6_reg;
    logic signed [H_W-1:0] h6_reg;
    logic [DSUM_W-1:0]     hh6_reg;
    logic [DSUM_W-1:0]     ac6_reg;
    logic                  cneg6_reg;
    logic                  z6_reg;
    logic [DSUM_W-1:0]     hh_next;
    logic [DSUM_W-1:0]     ac_next;

    always_comb begin
        hh_next = '0;
        ac_next = '0;
        for (int i = 0; i < N_LIMB; i++) begin
            for (int j = 0; j < N_LIMB; j++)
                hh_next = hh_next + (DSUM_W'(hpp5_reg[i][j]) << (LIMB_W * (i + j)));
        end
        for (int i = 0; i < 2; i++) begin
            for (int j = 0; j < N_LIMB; j++)
                ac_next = ac_next + (DSUM_W'(app5_reg[i][j]) << (LIMB_W * (i + j)));
        end
    end
    always_ff @(posedge aclk) begin
        if (!aresetn) v6_reg <= 1'b0;
        else if (en)  v6_reg <= v5_reg;
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            r6_reg    <= r5_reg;
            a6_reg    <= a5_reg;
            h6_reg    <= h5_reg;
            hh6_reg   <= hh_next;
            ac6_reg   <= ac_next;
            cneg6_reg <= cneg5_reg;
            z6_reg    <= z5_reg;
        end
    end

    // ---------------- stage 7: discriminant, root setup ----------------
    logic              sq_v_reg    [SQ_N+1];
    logic [DISC_W-1:0] sq_rad_reg  [SQ_N+1];
    logic [REM_W-1:0]  sq_rem_reg  [SQ_N+1];
    logic [SQ_N-1:0]   sq_root_reg [SQ_N+1];
    sqc_t              sq_c_reg    [SQ_N+1];
    logic [DSUM_W-1:0] disc_next;

    assign disc_next = cneg6_reg ? hh6_reg + ac6_reg : hh6_reg - ac6_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) sq_v_reg[0] <= 1'b0;
        else if (en)  sq_v_reg[0] <= v6_reg;
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            sq_rad_reg[0]    <= disc_next[DISC_W-1:0];
            sq_rem_reg[0]    <= '0;
            sq_root_reg[0]   <= '0;
            sq_c_reg[0].ray  <= r6_reg;
            sq_c_reg[0].h    <= h6_reg;
            sq_c_reg[0].a    <= a6_reg;
            sq_c_reg[0].miss <= z6_reg || disc_next[DSUM_W-1];
        end
    end

    // floor square root, one root bit per stage
    for (genvar k = 0; k < SQ_N; k++) begin : g_sqrt
        logic [1:0]       top_next;
        logic [REM_W-1:0] rem2_next;
        logic [REM_W-1:0] trial_next;
        logic             ge_next;

        assign top_next   = sq_rad_reg[k][DISC_W-1 -: 2];
        assign rem2_next  = {sq_rem_reg[k][REM_W-3:0], top_next};
        assign trial_next = {sq_root_reg[k], 2'b01};
        assign ge_next    = rem2_next >= trial_next;

        always_ff @(posedge aclk) begin
            if (!aresetn) sq_v_reg[k+1] <= 1'b0;
            else if (en)  sq_v_reg[k+1] <= sq_v_reg[k];
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                sq_rad_reg[k+1]  <= sq_rad_reg[k] << 2;
                sq_rem_reg[k+1]  <= ge_next ? rem2_next - trial_next : rem2_next;
                sq_root_reg[k+1] <= {sq_root_reg[k][SQ_N-2:0], ge_next};
                sq_c_reg[k+1]    <= sq_c_reg[k];
            end
        end
    end

    // ---------------- numerators of both roots ----------------
    logic             dv_v_reg   [NUM_W+1];
    logic [NUM_W-1:0] dv_nq_reg  [NUM_W+1][2];
    logic [A_W-1:0]   dv_rem_reg [NUM_W+1][2];
    dvc_t             dv_c_reg   [NUM_W+1];
    logic signed [NR_W-1:0] hx_next;
    logic signed [NR_W-1:0] sx_next;
    logic signed [NR_W-1:0] rt_next [2];
    logic signed [NR_W-1:0] rmag_next [2];

    always_comb begin
        hx_next      = NR_W'(sq_c_reg[SQ_N].h);
        sx_next      = $signed({2'b00, 1'b0, sq_root_reg[SQ_N]});
        rt_next[0]   = -hx_next - sx_next;
        rt_next[1]   = -hx_next + sx_next;
        for (int j = 0; j < 2; j++)
            rmag_next[j] = rt_next[j][NR_W-1] ? -rt_next[j] : rt_next[j];
    end
    always_ff @(posedge aclk) begin
        if (!aresetn) dv_v_reg[0] <= 1'b0;
        else if (en)  dv_v_reg[0] <= sq_v_reg[SQ_N];
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int j = 0; j < 2; j++) begin
                dv_nq_reg[0][j]  <= {rmag_next[j][NR_W-2:0], {FRAC_BITS{1'b0}}};
                dv_rem_reg[0][j] <= '0;
                dv_c_reg[0].neg[j] <= rt_next[j][NR_W-1];
            end
            dv_c_reg[0].ray  <= sq_c_reg[SQ_N].ray;
            dv_c_reg[0].a    <= sq_c_reg[SQ_N].a;
            dv_c_reg[0].miss <= sq_c_reg[SQ_N].miss;
        end
    end

    // restoring dividers by A, near root in lane 0 and far root in lane 1
    for (genvar k = 0; k < NUM_W; k++) begin : g_tdiv
        always_ff @(posedge aclk) begin
            if (!aresetn) dv_v_reg[k+1] <= 1'b0;
            else if (en)  dv_v_reg[k+1] <= dv_v_reg[k];
        end
        always_ff @(posedge aclk) begin
            if (en) dv_c_reg[k+1] <= dv_c_reg[k];
        end
        for (genvar j = 0; j < 2; j++) begin : g_lane
            logic [A_W:0] rem2_next;
            logic [A_W:0] sub_next;
            logic         ge_next;

            assign rem2_next = {dv_rem_reg[k][j], dv_nq_reg[k][j][NUM_W-1]};
            assign sub_next  = rem2_next - {1'b0, dv_c_reg[k].a};
            assign ge_next   = rem2_next >= {1'b0, dv_c_reg[k].a};

            always_ff @(posedge aclk) begin
                if (en) begin
                    dv_rem_reg[k+1][j] <= ge_next ? sub_next[A_W-1:0] : rem2_next[A_W-1:0];
                    dv_nq_reg[k+1][j]  <= {dv_nq_reg[k][j][NUM_W-2:0], ge_next};
                end
            end
        end
    end

    // ---------------- t1: signed root values ----------------
    logic                 t1_v_reg;
    ray_t                 t1_ray_reg;
    logic                 t1_miss_reg;
    logic signed [TW-1:0] t1_t_reg [2];
    logic signed [TW-1:0] tq_next [2];

    always_comb begin
        for (int j = 0; j < 2; j++) begin
            tq_next[j] = $signed({1'b0, dv_nq_reg[NUM_W][j]});
            if (dv_c_reg[NUM_W].neg[j]) tq_next[j] = -tq_next[j];
        end
    end
    always_ff @(posedge aclk) begin
        if (!aresetn) t1_v_reg <= 1'b0;
        else if (en)  t1_v_reg <= dv_v_reg[NUM_W];
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            t1_ray_reg  <= dv_c_reg[NUM_W].ray;
            t1_miss_reg <= dv_c_reg[NUM_W].miss;
            t1_t_reg[0] <= tq_next[0];
            t1_t_reg[1] <= tq_next[1];
        end
    end

    // ---------------- t2: interval tests and root choice ----------------
    logic                      t2_v_reg;
    ray_t                      t2_ray_reg;
    logic                      t2_hit_reg;
    logic                      t2_back_reg;
    logic signed [COORD_W-1:0] t2_t_reg;
    logic signed [TW-1:0]      lo_next;
    logic signed [TW-1:0]      hi_next;
    logic signed [TW-1:0]      tsel_next;
    logic                      far_next;
    logic                      hit_next;

    always_comb begin
        lo_next   = TW'(t1_ray_reg.tlo);
        hi_next   = TW'(t1_ray_reg.thi);
        far_next  = t1_t_reg[0] < lo_next;
        tsel_next = far_next ? t1_t_reg[1] : t1_t_reg[0];
        hit_next  = !t1_miss_reg && !(far_next && (t1_t_reg[1] < lo_next))
                    && !(tsel_next > hi_next);
    end
    always_ff @(posedge aclk) begin
        if (!aresetn) t2_v_reg <= 1'b0;
        else if (en)  t2_v_reg <= t1_v_reg;
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            t2_ray_reg  <= t1_ray_reg;
            t2_hit_reg  <= hit_next;
            t2_back_reg <= far_next;
            t2_t_reg    <= tsel_next[COORD_W-1:0];
        end
    end

    // ---------------- m: t * dir ----------------
    logic                        m_v_reg;
    logic signed [COORD_W-1:0]   m_o_reg [3];
    logic signed [2*COORD_W-1:0] m_prod_reg [3];
    logic                        m_hit_reg;
    logic                        m_back_reg;
    logic signed [COORD_W-1:0]   m_t_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) m_v_reg <= 1'b0;
        else if (en)  m_v_reg <= t2_v_reg;
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                m_o_reg[i]    <= t2_ray_reg.o[i];
                m_prod_reg[i] <= t2_t_reg * t2_ray_reg.d[i];
            end
            m_hit_reg  <= t2_hit_reg;
            m_back_reg <= t2_back_reg;
            m_t_reg    <= t2_t_reg;
        end
    end

    // ---------------- p: hit point and offset from center ----------------
    logic                      p_v_reg;
    logic signed [PW-1:0]      p_pt_reg [3];
    logic signed [DIFF_W-1:0]  p_df_reg [3];
    logic                      p_hit_reg;
    logic                      p_back_reg;
    logic signed [COORD_W-1:0] p_t_reg;
    logic signed [PW-1:0]      pt_next [3];

    always_comb begin
        for (int i = 0; i < 3; i++)
            pt_next[i] = PW'(m_o_reg[i]) + PW'(m_prod_reg[i] >>> FRAC_BITS);
    end
    always_ff @(posedge aclk) begin
        if (!aresetn) p_v_reg <= 1'b0;
        else if (en)  p_v_reg <= m_v_reg;
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                p_pt_reg[i] <= pt_next[i];
                p_df_reg[i] <= DIFF_W'(pt_next[i]) - DIFF_W'(cen_reg[i]);
            end
            p_hit_reg  <= m_hit_reg;
            p_back_reg <= m_back_reg;
            p_t_reg    <= m_t_reg;
        end
    end

    // ---------------- q: normal numerators, point saturation ----------------
    logic             nd_v_reg   [NN_W+1];
    logic [NN_W-1:0]  nd_nq_reg  [NN_W+1][3];
    logic [RAD_W-1:0] nd_rem_reg [NN_W+1][3];
    ndc_t             nd_c_reg   [NN_W+1];
    logic signed [DIFF_W-1:0] dn_next  [3];
    logic signed [DIFF_W-1:0] dm_next  [3];
    logic signed [COORD_W-1:0] ps_next [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            dn_next[i] = p_back_reg ? -p_df_reg[i] : p_df_reg[i];
            dm_next[i] = dn_next[i][DIFF_W-1] ? -dn_next[i] : dn_next[i];
            if (p_pt_reg[i] > P_MAX)      ps_next[i] = P_MAX[COORD_W-1:0];
            else if (p_pt_reg[i] < P_MIN) ps_next[i] = P_MIN[COORD_W-1:0];
            else                          ps_next[i] = p_pt_reg[i][COORD_W-1:0];
        end
    end
    always_ff @(posedge aclk) begin
        if (!aresetn) nd_v_reg[0] <= 1'b0;
        else if (en)  nd_v_reg[0] <= p_v_reg;
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                nd_nq_reg[0][i]     <= {dm_next[i], {FRAC_BITS{1'b0}}};
                nd_rem_reg[0][i]    <= '0;
                nd_c_reg[0].neg[i]  <= dn_next[i][DIFF_W-1];
                nd_c_reg[0].psat[i] <= ps_next[i];
            end
            nd_c_reg[0].hit  <= p_hit_reg;
            nd_c_reg[0].back <= p_back_reg;
            nd_c_reg[0].tt   <= p_t_reg;
        end
    end

    // restoring dividers by the radius, one lane per axis
    for (genvar k = 0; k < NN_W; k++) begin : g_ndiv
        always_ff @(posedge aclk) begin
            if (!aresetn) nd_v_reg[k+1] <= 1'b0;
            else if (en)  nd_v_reg[k+1] <= nd_v_reg[k];
        end
        always_ff @(posedge aclk) begin
            if (en) nd_c_reg[k+1] <= nd_c_reg[k];
        end
        for (genvar j = 0; j < 3; j++) begin : g_lane
            logic [RAD_W:0] rem2_next;
            logic [RAD_W:0] sub_next;
            logic           ge_next;

            assign rem2_next = {nd_rem_reg[k][j], nd_nq_reg[k][j][NN_W-1]};
            assign sub_next  = rem2_next - {1'b0, rad_reg};
            assign ge_next   = rem2_next >= {1'b0, rad_reg};

            always_ff @(posedge aclk) begin
                if (en) begin
                    nd_rem_reg[k+1][j] <= ge_next ? sub_next[RAD_W-1:0]
                                                  : rem2_next[RAD_W-1:0];
                    nd_nq_reg[k+1][j]  <= {nd_nq_reg[k][j][NN_W-2:0], ge_next};
                end
            end
        end
    end

    // ---------------- result stage ----------------
    logic                     res_v_reg;
    logic [OUT_W-1:0]         res_data_reg;
    logic [USER_W-1:0]        res_user_reg;
    logic [NN_W-1:0]          qc_next   [3];
    logic signed [NORM_W-1:0] nrm_next  [3];
    logic [OUT_W-1:0]         data_next;
    ndc_t                     fin_c;

    always_comb begin
        fin_c = nd_c_reg[NN_W];
        for (int i = 0; i < 3; i++) begin
            qc_next[i]  = (nd_nq_reg[NN_W][i] > NN_W'(NORM_LIM)) ? NN_W'(NORM_LIM)
                                                                 : nd_nq_reg[NN_W][i];
            nrm_next[i] = fin_c.neg[i] ? -$signed(qc_next[i][NORM_W-1:0])
                                       : $signed(qc_next[i][NORM_W-1:0]);
        end
        data_next = {7'b0, nrm_next[2], nrm_next[1], nrm_next[0],
                     fin_c.psat[2], fin_c.psat[1], fin_c.psat[0], fin_c.tt};
        // drop every field on a miss
        if (!fin_c.hit) data_next = '0;
    end
    always_ff @(posedge aclk) begin
        if (!aresetn) res_v_reg <= 1'b0;
        else if (en)  res_v_reg <= nd_v_reg[NN_W];
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            res_data_reg <= data_next;
            res_user_reg <= {fin_c.hit && fin_c.back, fin_c.hit};
        end
    end

    // ---------------- output register and skid ----------------
    logic              out_v_reg;
    logic [OUT_W-1:0]  out_data_reg;
    logic [USER_W-1:0] out_user_reg;
    logic [OUT_W-1:0]  skid_data_reg;
    logic [USER_W-1:0] skid_user_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end else if (skid_v_reg) begin
            if (m_tready) skid_v_reg <= 1'b0;
        end else if (res_v_reg) begin
            // park the item in the skid when the output is still held
            if (!out_v_reg || m_tready) out_v_reg  <= 1'b1;
            else                        skid_v_reg <= 1'b1;
        end else if (m_tready) begin
            out_v_reg <= 1'b0;
        end
    end
    always_ff @(posedge aclk) begin
        if (skid_v_reg) begin
            if (m_tready) begin
                out_data_reg <= skid_data_reg;
                out_user_reg <= skid_user_reg;
            end
        end else if (res_v_reg) begin
            if (!out_v_reg || m_tready) begin
                out_data_reg <= res_data_reg;
                out_user_reg <= res_user_reg;
            end else begin
                skid_data_reg <= res_data_reg;
                skid_user_reg <= res_user_reg;
            end
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

endmodule
